### design/hetach_pkg.sv
`timescale 1ns / 1ps

package hetach_pkg;

   // field widths
   localparam int EDGE_W     = 32;
   localparam int TIME_W     = 32;
   localparam int EPR_W      = 8;
   localparam int STALE_W    = 16;
   localparam int RPM_W      = 32;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // 60000 * 256 = 0x753 << 13
   localparam int                 RPM_K_W     = 11;
   localparam logic [RPM_K_W-1:0] RPM_K       = 11'h753;
   localparam int                 RPM_K_SHIFT = 13;

   // divider operand widths
   localparam int NUM_W = EDGE_W + RPM_K_W + RPM_K_SHIFT;
   localparam int DEN_W = TIME_W + EPR_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EDGES_PER_REV = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_MS      = 1'b1;

   // register reset values
   localparam logic [EPR_W-1:0]   EPR_RESET   = 8'd24;
   localparam logic [STALE_W-1:0] STALE_RESET = 16'd500;

   // input actions
   localparam logic ACT_EDGE   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_MEASURED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRIMING  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ROLLOVER = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO_INT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STALE    = 3'd4;

   typedef struct packed {
      logic              action;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [RPM_W-1:0]    rpm_q8;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

### design/hetach_mul.sv
`timescale 1ns / 1ps

// shift-add multiplier, one multiplier bit per cycle, msb first
module hetach_mul #(
   parameter int WA = 32,
   parameter int WB = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WA-1:0]    a,
   input  logic [WB-1:0]    b,
   output logic             busy,
   output logic [WA+WB-1:0] product
);

   localparam int CNT_W = $clog2(WB + 1);
   localparam int P_W   = WA + WB;

   logic [CNT_W-1:0] cnt_ff;
   logic [P_W-1:0]   acc_ff;
   logic [P_W-1:0]   acc_in;
   logic [WA-1:0]    a_ff;
   logic [WB-1:0]    b_ff;

   assign acc_in  = {acc_ff[P_W-2:0], 1'b0} + (b_ff[WB-1] ? P_W'(a_ff) : '0);
   assign busy    = (cnt_ff != '0);
   assign product = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(WB);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= a;
         b_ff   <= b;
      end else if (busy) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[WB-2:0], 1'b0};
      end
   end

endmodule

### design/hetach_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, saturating quotient
module hetach_div #(
   parameter int NUM_W = 56,
   parameter int DEN_W = 40,
   parameter int Q_W   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [Q_W-1:0]   quot
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [Q_W-1:0]   low_ff;
   logic [DEN_W-1:0] num_hi;
   logic             sat;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;
   logic             q_bit;

   // quotient overflows when the bits above the quotient already reach the divisor
   assign num_hi = DEN_W'(num[NUM_W-1:Q_W]);
   assign sat    = (num_hi >= den);

   assign rem_sh = {rem_ff, low_ff[Q_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign q_bit  = ~diff[DEN_W];

   assign busy = (cnt_ff != '0);
   assign quot = low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= (den == '0 || sat) ? '0 : CNT_W'(Q_W);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= num_hi;
         if (den == '0) begin
            low_ff <= (num != '0) ? '1 : '0;
         end else if (sat) begin
            low_ff <= '1;
         end else begin
            low_ff <= num[Q_W-1:0];
         end
      end else if (busy) begin
         rem_ff <= q_bit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         low_ff <= {low_ff[Q_W-2:0], q_bit};
      end
   end

endmodule

### design/hall_edge_tachometer.sv
`timescale 1ns / 1ps

// channel  ports                         direction  word
// req      req_valid req_ready req_word   in         action, now_ms
// rsp      rsp_valid rsp_ready rsp_word   out        rpm_q8, status
// csr      csr_we csr_index csr_wdata     in         edges_per_rev, stale_ms
//
// edge event: taken whenever the block is idle, gives no word
// sample: a computed speed goes through the shift-add multipliers, then the bit-serial
//   divider, which skips a zero-divisor or saturating divide; other samples go to output
// one sample is in flight at a time; req_ready is low until its word is in rsp
// the rsp register holds a finished word while the next item is accepted; rsp stalls keep
//   the block in its output state; reset is synchronous and skips the payload registers

module hall_edge_tachometer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hetach_pkg::req_type                req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output hetach_pkg::rsp_type                rsp_word,
   input  logic                               csr_we,
   input  logic [hetach_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hetach_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [hetach_pkg::EPR_W-1:0]   epr_ff;
   logic [hetach_pkg::STALE_W-1:0] stale_ff;

   // tachometer state
   logic [hetach_pkg::EDGE_W-1:0] edge_count_ff;
   logic [hetach_pkg::EDGE_W-1:0] last_edge_ff;
   logic [hetach_pkg::TIME_W-1:0] last_time_ff;

   // result being built
   logic [hetach_pkg::RPM_W-1:0]    rpm_ff;
   logic [hetach_pkg::STATUS_W-1:0] status_ff;
   logic                            rsp_valid_ff;
   hetach_pkg::rsp_type             rsp_word_ff;

   // sample classification
   logic                            accept;
   logic                            sample;
   logic [hetach_pkg::TIME_W-1:0]   d_ms;
   logic [hetach_pkg::EDGE_W-1:0]   d_edges;
   logic [hetach_pkg::STATUS_W-1:0] status_in;
   logic                            store;
   logic                            compute;

   // arithmetic units
   logic                                            mul_start;
   logic                                            num_busy;
   logic                                            den_busy;
   logic [hetach_pkg::EDGE_W+hetach_pkg::RPM_K_W-1:0] num_prod;
   logic [hetach_pkg::DEN_W-1:0]                    den_prod;
   logic [hetach_pkg::NUM_W-1:0]                    num;
   logic                                            div_start;
   logic                                            div_busy;
   logic [hetach_pkg::RPM_W-1:0]                    quot;
   logic                                            out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign sample    = (req_word.action == hetach_pkg::ACT_SAMPLE);

   assign d_ms    = req_word.now_ms - last_time_ff;
   assign d_edges = edge_count_ff - last_edge_ff;

   // decide the sample case from the stored time and edge count
   always_comb begin
      store     = 1'b1;
      compute   = 1'b0;
      status_in = hetach_pkg::ST_MEASURED;
      if (last_time_ff == '0) begin
         status_in = hetach_pkg::ST_PRIMING;
      end else if (req_word.now_ms < last_time_ff) begin
         status_in = hetach_pkg::ST_ROLLOVER;
      end else if (req_word.now_ms == last_time_ff) begin
         status_in = hetach_pkg::ST_ZERO_INT;
         store     = 1'b0;
      end else if (d_edges == '0 &&
                   d_ms > hetach_pkg::TIME_W'(stale_ff)) begin
         status_in = hetach_pkg::ST_STALE;
      end else begin
         compute   = 1'b1;
      end
   end

   // numerator: d_edges * 0x753, later shifted up by 13
   // denominator: d_ms * edges_per_rev
   assign mul_start = accept && sample && compute;

   hetach_mul #(
      .WA (hetach_pkg::EDGE_W),
      .WB (hetach_pkg::RPM_K_W)
   ) u_num_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (d_edges),
      .b       (hetach_pkg::RPM_K),
      .busy    (num_busy),
      .product (num_prod)
   );

   hetach_mul #(
      .WA (hetach_pkg::TIME_W),
      .WB (hetach_pkg::EPR_W)
   ) u_den_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (d_ms),
      .b       (epr_ff),
      .busy    (den_busy),
      .product (den_prod)
   );

   assign num       = {num_prod, {hetach_pkg::RPM_K_SHIFT{1'b0}}};
   assign div_start = (state_ff == S_MUL) && !num_busy && !den_busy;

   // quotient truncated, saturated at all ones; zero divisor handled inside
   hetach_div #(
      .NUM_W (hetach_pkg::NUM_W),
      .DEN_W (hetach_pkg::DEN_W),
      .Q_W   (hetach_pkg::RPM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den_prod),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // control, tachometer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         epr_ff        <= hetach_pkg::EPR_RESET;
         stale_ff      <= hetach_pkg::STALE_RESET;
         edge_count_ff <= '0;
         last_edge_ff  <= '0;
         last_time_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               hetach_pkg::CSR_EDGES_PER_REV:
                  epr_ff <= csr_wdata[hetach_pkg::EPR_W-1:0];
               hetach_pkg::CSR_STALE_MS:
                  stale_ff <= csr_wdata[hetach_pkg::STALE_W-1:0];
               default: ;
            endcase
         end

         // the output state reloads the word itself
         if (rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (!sample) begin
                     edge_count_ff <= edge_count_ff + 1'b1;
                  end else begin
                     if (store) begin
                        last_time_ff <= req_word.now_ms;
                        last_edge_ff <= edge_count_ff;
                     end
                     state_ff <= compute ? S_MUL : S_OUT;
                  end
               end
            end
            S_MUL: begin
               if (div_start) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!div_busy) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && sample) begin
         status_ff <= status_in;
         rpm_ff    <= '0;
      end else if (state_ff == S_DIV && !div_busy) begin
         rpm_ff <= quot;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_word_ff.rpm_q8 <= rpm_ff;
         rsp_word_ff.status <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
